@@ sv/rbd_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rbd_pkg
// Shared constants, types and ring index helpers for the ring buffer deque.
// ---------------------------------------------------------------------------
package rbd_pkg;

    localparam int CAPACITY = 16;
    localparam int ELEM_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ_SLOT  = 3'd4
    } t_opcode;

    // Write port and read addresses handed from the core to the slot RAMs
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [ELEM_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr_front;
        logic [IDX_W-1:0]  raddr_back;
        logic [IDX_W-1:0]  raddr_slot;
    } t_ram_req;

    // Result-side control: handshake plus the non-RAM result fields
    typedef struct packed {
        logic             valid;
        logic             accepted;
        logic [CNT_W-1:0] occupancy;
        logic             is_empty;
        logic             is_full;
        logic             rv_front;
        logic             rv_back;
        logic             rv_slot;
    } t_res_ctrl;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        ring_next = (idx == IDX_W'(CAPACITY - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
        ring_prev = (idx == '0) ? IDX_W'(CAPACITY - 1) : idx - 1'b1;
    endfunction

endpackage
`default_nettype wire

@@ sv/ring_buffer_deque.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ring_buffer_deque
// Fixed-capacity double-ended queue on a ring of slots, stream interface.
// ---------------------------------------------------------------------------
// Each input transfer carries one operation (push back, push front, pop back,
// pop front, read slot) and yields exactly one result transfer reporting the
// state after that operation. The block takes one transfer per cycle while
// the result side keeps up. The operation waits in the input register while
// the next indices and count are formed; once the result side is free or
// ready, the indices and count update and the slot RAMs capture their reads
// at the post-step addresses, and the result registers offer the result to
// the receiver. A waiting result holds the input register, so at most two
// operations are in flight. Pushes are refused when full and pops when empty
// (accepted = 0, nothing changes). Slots clear at reset through per-slot
// valid bits, so there is no clearing pass and the block is ready right after
// reset.
module ring_buffer_deque
    import rbd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [39:0]  s_axis_tdata,  // value[31:0], slot_index[35:32], zero pad
    input  wire logic [2:0]   s_axis_tuser,  // opcode[2:0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [103:0] m_axis_tdata   // accepted[0], front_value[32:1],
                                             // back_value[64:33], slot_value[96:65],
                                             // occupancy[101:97], is_empty[102],
                                             // is_full[103]
);

    t_ram_req          req;
    t_res_ctrl         res;
    logic [ELEM_W-1:0] front_data, back_data, slot_data;

    rbd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_opcode     (s_axis_tuser),
        .i_value      (s_axis_tdata[31:0]),
        .i_slot_index (s_axis_tdata[35:32]),
        .i_out_ready  (m_axis_tready),
        .o_req        (req),
        .o_res        (res)
    );

    rbd_ram #(.DEPTH(CAPACITY), .WIDTH(ELEM_W)) u_ram_front (
        .i_clk   (i_clk),
        .i_we    (req.we),
        .i_waddr (req.waddr),
        .i_wdata (req.wdata),
        .i_re    (req.re),
        .i_raddr (req.raddr_front),
        .o_rdata (front_data)
    );

    rbd_ram #(.DEPTH(CAPACITY), .WIDTH(ELEM_W)) u_ram_back (
        .i_clk   (i_clk),
        .i_we    (req.we),
        .i_waddr (req.waddr),
        .i_wdata (req.wdata),
        .i_re    (req.re),
        .i_raddr (req.raddr_back),
        .o_rdata (back_data)
    );

    rbd_ram #(.DEPTH(CAPACITY), .WIDTH(ELEM_W)) u_ram_slot (
        .i_clk   (i_clk),
        .i_we    (req.we),
        .i_waddr (req.waddr),
        .i_wdata (req.wdata),
        .i_re    (req.re),
        .i_raddr (req.raddr_slot),
        .o_rdata (slot_data)
    );

    assign m_axis_tvalid = res.valid;

    always_comb begin
        m_axis_tdata          = '0;
        m_axis_tdata[0]       = res.accepted;
        m_axis_tdata[32:1]    = res.rv_front ? front_data : '0;
        m_axis_tdata[64:33]   = res.rv_back  ? back_data  : '0;
        m_axis_tdata[96:65]   = res.rv_slot  ? slot_data  : '0;
        m_axis_tdata[101:97]  = res.occupancy;
        m_axis_tdata[102]     = res.is_empty;
        m_axis_tdata[103]     = res.is_full;
    end

endmodule
`default_nettype wire

@@ sv/rbd_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rbd_ram
// Generic single-write, single-read RAM with registered, write-first read.
// ---------------------------------------------------------------------------
module rbd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Forward the word being written when the read hits the same address
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ sv/rbd_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rbd_core
// Input register, deque indices, item count and slot valid bits; computes
// the next state and drives the slot RAM ports for one transfer per cycle while the result side keeps up.
// ---------------------------------------------------------------------------
module rbd_core
    import rbd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [ELEM_W-1:0] i_value,
    input  wire logic [IDX_W-1:0]  i_slot_index,
    input  wire logic              i_out_ready,
    output t_ram_req               o_req,
    output t_res_ctrl              o_res
);

    // Input register
    logic              r_in_valid;
    logic [OP_W-1:0]   r_op;
    logic [ELEM_W-1:0] r_value;
    logic [IDX_W-1:0]  r_slot_index;

    // Deque state
    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_back,  n_back;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_slot_valid [CAPACITY];

    // Result control
    logic             r_out_valid;
    logic             r_accepted, n_accepted;
    logic             r_rv_front, r_rv_back, r_rv_slot;

    logic fire;
    logic in_take;
    logic full, empty;
    logic we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] ra_front, ra_back;

    assign fire    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_ready = !r_in_valid || fire;
    assign in_take = i_valid && o_ready;

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        n_front    = r_front;
        n_back     = r_back;
        n_count    = r_count;
        n_accepted = 1'b0;
        we         = 1'b0;
        waddr      = r_back;
        case (t_opcode'(r_op))
            OP_PUSH_BACK: begin
                if (!full) begin
                    we         = 1'b1;
                    waddr      = r_back;
                    n_back     = ring_next(r_back);
                    n_count    = r_count + 1'b1;
                    n_accepted = 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (!full) begin
                    we         = 1'b1;
                    waddr      = r_front;
                    n_front    = ring_prev(r_front);
                    n_count    = r_count + 1'b1;
                    n_accepted = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (!empty) begin
                    n_back     = ring_prev(r_back);
                    n_count    = r_count - 1'b1;
                    n_accepted = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (!empty) begin
                    n_front    = ring_next(r_front);
                    n_count    = r_count - 1'b1;
                    n_accepted = 1'b1;
                end
            end
            OP_READ_SLOT: begin
                n_accepted = 1'b1;
            end
            default: begin
                n_accepted = 1'b0;
            end
        endcase
    end

    // Read addresses come from the post-step indices
    assign ra_front = ring_next(n_front);
    assign ra_back  = ring_prev(n_back);

    always_comb begin
        o_req.we          = fire && we;
        o_req.waddr       = waddr;
        o_req.wdata       = r_value;
        o_req.re          = fire;
        o_req.raddr_front = ra_front;
        o_req.raddr_back  = ra_back;
        o_req.raddr_slot  = r_slot_index;
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op         <= i_opcode;
            r_value      <= i_value;
            r_slot_index <= i_slot_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_front     <= IDX_W'(CAPACITY - 1);
            r_back      <= '0;
            r_count     <= '0;
            r_accepted  <= 1'b0;
            r_rv_front  <= 1'b0;
            r_rv_back   <= 1'b0;
            r_rv_slot   <= 1'b0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_slot_valid[i] <= 1'b0;
            end
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_front    <= n_front;
                r_back     <= n_back;
                r_count    <= n_count;
                r_accepted <= n_accepted;
                // A slot never written reads as zero
                r_rv_front <= r_slot_valid[ra_front] || (we && (waddr == ra_front));
                r_rv_back  <= r_slot_valid[ra_back] || (we && (waddr == ra_back));
                r_rv_slot  <= r_slot_valid[r_slot_index] || (we && (waddr == r_slot_index));
                if (we) begin
                    r_slot_valid[waddr] <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_res.valid     = r_out_valid;
        o_res.accepted  = r_accepted;
        o_res.occupancy = r_count;
        o_res.is_empty  = (r_count == '0);
        o_res.is_full   = (r_count == CNT_W'(CAPACITY));
        o_res.rv_front  = r_rv_front;
        o_res.rv_back   = r_rv_back;
        o_res.rv_slot   = r_rv_slot;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("item count above capacity");

    a_ring_invariant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_back == IDX_W'(r_front + 1 + r_count))
        else $error("front, back and count out of step");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.we |-> !full)
        else $error("slot written while full");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_count) && $stable(r_front) && $stable(r_back))
        else $error("state moved without a transfer");

    a_accept_moves_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_accepted && (r_op == OP_PUSH_BACK || r_op == OP_PUSH_FRONT))
        |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted push did not raise count");

endmodule
`default_nettype wire
